/* hdl/wsu_pkg.sv */
// package: types and constants shared by the frame unmasker modules
package wsu_pkg;

  typedef enum logic [2:0] {
    PH_HDR0   = 3'd0,
    PH_HDR1   = 3'd1,
    PH_EXT_HI = 3'd2,
    PH_EXT_LO = 3'd3,
    PH_KEY    = 3'd4,
    PH_DATA   = 3'd5
  } phase_t;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_NO_MASK = 2'd1;
  localparam logic [1:0] ERR_LEN64   = 2'd2;

  localparam logic       MASK_BIT_SET = 1'b1;
  localparam logic [6:0] LEN_EXT16    = 7'd126;
  localparam logic [6:0] LEN_EXT64    = 7'd127;
  localparam logic [1:0] KEY_LAST_IDX = 2'd3;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0]  data;
    logic [7:0]  key_byte;
    logic        last;
    logic        empty;
    logic [15:0] length;
    logic [31:0] key;
    logic [1:0]  err;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } qwr_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qrd_t;

endpackage

/* hdl/wsu_front.sv */
// front end: header parser that classifies each byte and queues result entries
module wsu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    frame_byte,
  output wsu_pkg::qwr_t qwr
);

  wsu_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  kidx_r, kidx_nxt;
  logic [6:0]  len7;
  logic [7:0]  kbyte;

  assign len7 = frame_byte[6:0];

  always_comb begin
    unique case (kidx_r)
      2'd0: kbyte = key_r[31:24];
      2'd1: kbyte = key_r[23:16];
      2'd2: kbyte = key_r[15:8];
      default: kbyte = key_r[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wsu_pkg::PH_HDR0;
      len_r   <= '0;
      rem_r   <= '0;
      key_r   <= '0;
      kidx_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      rem_r   <= rem_nxt;
      key_r   <= key_nxt;
      kidx_r  <= kidx_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    key_nxt   = key_r;
    kidx_nxt  = kidx_r;
    qwr       = '0;
    if (accept) begin
      unique case (phase_r)
        wsu_pkg::PH_HDR1: begin
          if (frame_byte[7] != wsu_pkg::MASK_BIT_SET) begin
            phase_nxt     = wsu_pkg::PH_HDR0;
            qwr.push      = 1'b1;
            qwr.entry.err = wsu_pkg::ERR_NO_MASK;
          end else if (len7 == wsu_pkg::LEN_EXT64) begin
            phase_nxt     = wsu_pkg::PH_HDR0;
            qwr.push      = 1'b1;
            qwr.entry.err = wsu_pkg::ERR_LEN64;
          end else if (len7 == wsu_pkg::LEN_EXT16) begin
            phase_nxt = wsu_pkg::PH_EXT_HI;
          end else begin
            len_nxt   = {9'd0, len7};
            kidx_nxt  = '0;
            phase_nxt = wsu_pkg::PH_KEY;
          end
        end
        wsu_pkg::PH_EXT_HI: begin
          len_nxt   = {frame_byte, 8'd0};
          phase_nxt = wsu_pkg::PH_EXT_LO;
        end
        wsu_pkg::PH_EXT_LO: begin
          len_nxt   = {len_r[15:8], frame_byte};
          kidx_nxt  = '0;
          phase_nxt = wsu_pkg::PH_KEY;
        end
        wsu_pkg::PH_KEY: begin
          key_nxt = {key_r[23:0], frame_byte};
          if (kidx_r != wsu_pkg::KEY_LAST_IDX) begin
            kidx_nxt = kidx_r + 2'd1;
          end else begin
            kidx_nxt = '0;
            if (len_r == 16'd0) begin
              phase_nxt       = wsu_pkg::PH_HDR0;
              qwr.push        = 1'b1;
              qwr.entry.empty = 1'b1;
              qwr.entry.key   = key_nxt;
            end else begin
              rem_nxt   = len_r;
              phase_nxt = wsu_pkg::PH_DATA;
            end
          end
        end
        wsu_pkg::PH_DATA: begin
          kidx_nxt           = kidx_r + 2'd1;
          rem_nxt            = rem_r - 16'd1;
          qwr.push           = 1'b1;
          qwr.entry.data     = frame_byte;
          qwr.entry.key_byte = kbyte;
          qwr.entry.last     = (rem_r == 16'd1);
          qwr.entry.length   = len_r;
          qwr.entry.key      = key_r;
          if (rem_r == 16'd1) begin
            phase_nxt = wsu_pkg::PH_HDR0;
          end
        end
        default: begin
          phase_nxt = wsu_pkg::PH_HDR1;
        end
      endcase
    end
  end

endmodule

/* hdl/wsu_queue.sv */
// short result queue between the header parser and the output stage
module wsu_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  wsu_pkg::qwr_t qwr,
  input  logic          pop,
  output logic          full,
  output wsu_pkg::qrd_t qrd
);

  wsu_pkg::entry_t mem_r [wsu_pkg::QDEPTH];
  logic [wsu_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [wsu_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic do_pop;

  assign full      = (cnt_r == wsu_pkg::QCNT_W'(wsu_pkg::QDEPTH));
  assign qrd.valid = (cnt_r != '0);
  assign qrd.entry = mem_r[rd_ptr_r];
  assign do_pop    = pop && qrd.valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (qwr.push && !do_pop) begin
      cnt_nxt = cnt_r + wsu_pkg::QCNT_W'(1);
    end else if (!qwr.push && do_pop) begin
      cnt_nxt = cnt_r - wsu_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (qwr.push) begin
        wr_ptr_r <= wr_ptr_r + wsu_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + wsu_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (qwr.push) begin
      mem_r[wr_ptr_r] <= qwr.entry;
    end
  end

endmodule

/* hdl/wsu_back.sv */
// back end: unmask xor and output register
module wsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  wsu_pkg::qrd_t qrd,
  output logic          pop,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [7:0]    out_payload_byte,
  output logic          out_last_of_frame,
  output logic          out_empty_frame,
  output logic [15:0]   out_frame_length,
  output logic [31:0]   out_xor_key,
  output logic [1:0]    out_error_code
);

  logic valid_r;

  assign pop       = qrd.valid && (!valid_r || out_ready);
  assign out_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_ready) begin
      valid_r <= qrd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_payload_byte  <= qrd.entry.data ^ qrd.entry.key_byte;
      out_last_of_frame <= qrd.entry.last;
      out_empty_frame   <= qrd.entry.empty;
      out_frame_length  <= qrd.entry.length;
      out_xor_key       <= qrd.entry.key;
      out_error_code    <= qrd.entry.err;
    end
  end

endmodule

/* hdl/websocket_frame_unmasker_top.sv */
// top level: websocket client frame unmasker, one byte per transaction
//
//  channel  direction  ports
//  in       input      in_valid, in_ready, in_frame_byte
//  out      output     out_valid, out_ready, out_payload_byte, out_last_of_frame,
//                      out_empty_frame, out_frame_length, out_xor_key, out_error_code
//
// one byte is accepted per cycle while in_ready is high
// in_ready falls only when the four-entry result queue is full
// the output register holds its transaction while out_ready is low
// rst_n is synchronous, active low, and returns the parser to header hunting
module websocket_frame_unmasker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_frame_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_of_frame,
  output logic        out_empty_frame,
  output logic [15:0] out_frame_length,
  output logic [31:0] out_xor_key,
  output logic [1:0]  out_error_code
);

  wsu_pkg::qwr_t qwr;
  wsu_pkg::qrd_t qrd;
  logic full;
  logic pop;

  assign in_ready = !full;

  wsu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_valid && in_ready),
    .frame_byte (in_frame_byte),
    .qwr        (qwr)
  );

  wsu_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .qwr   (qwr),
    .pop   (pop),
    .full  (full),
    .qrd   (qrd)
  );

  wsu_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .qrd               (qrd),
    .pop               (pop),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_payload_byte  (out_payload_byte),
    .out_last_of_frame (out_last_of_frame),
    .out_empty_frame   (out_empty_frame),
    .out_frame_length  (out_frame_length),
    .out_xor_key       (out_xor_key),
    .out_error_code    (out_error_code)
  );

endmodule

/* hdl/wsu_checker.sv */
// checker: port-level assertions for the frame unmasker, bound to the top level
module wsu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_payload_byte,
  input logic        out_last_of_frame,
  input logic        out_empty_frame,
  input logic [15:0] out_frame_length,
  input logic [31:0] out_xor_key,
  input logic [1:0]  out_error_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte)
      && $stable(out_frame_length) && $stable(out_error_code))
    else $error("output transaction changed while stalled");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != wsu_pkg::ERR_NONE |->
      out_payload_byte == 8'd0 && out_frame_length == 16'd0 && out_xor_key == 32'd0
      && !out_last_of_frame && !out_empty_frame)
    else $error("error result carries data");

  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_frame |->
      out_frame_length == 16'd0 && !out_last_of_frame && out_payload_byte == 8'd0
      && out_error_code == wsu_pkg::ERR_NONE)
    else $error("empty frame result malformed");

  a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code == wsu_pkg::ERR_NONE && !out_empty_frame |->
      out_frame_length != 16'd0)
    else $error("data byte with zero frame length");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error_code == wsu_pkg::ERR_NONE
      || out_error_code == wsu_pkg::ERR_NO_MASK || out_error_code == wsu_pkg::ERR_LEN64)
    else $error("undefined error code");

endmodule

bind websocket_frame_unmasker_top wsu_checker u_wsu_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_payload_byte  (out_payload_byte),
  .out_last_of_frame (out_last_of_frame),
  .out_empty_frame   (out_empty_frame),
  .out_frame_length  (out_frame_length),
  .out_xor_key       (out_xor_key),
  .out_error_code    (out_error_code)
);
